/* rtl/core/gpid_pkg.sv */
// Shared types, constants and helpers for the gain-scheduled incremental PID block.
// No dependencies; the front, back, multiplier, divider and top level import this package.
package gpid_pkg;

  // Breakpoints per curve, and the number of curves.
  localparam int NodesDef = 16;
  localparam int Curves   = 3;

  // Serial multiplier and divider operand widths.
  localparam int MulAW = 52;
  localparam int MulBW = 32;
  localparam int MulPW = MulAW + MulBW;
  localparam int DivNW = 50;
  localparam int DivDW = 32;

  // Saturation bound of one Q16.16 product, 2^60.
  localparam logic [67:0] SatBound = 68'(1) << 60;

  // Curve codes.
  localparam logic [1:0] CURVE_GAIN     = 2'd0;
  localparam logic [1:0] CURVE_INTEGRAL = 2'd1;
  localparam logic [1:0] CURVE_DERIV    = 2'd2;
  localparam logic [1:0] CURVE_NONE     = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_GAIN_CNT = 2'd0;
  localparam logic [1:0] REG_INT_CNT  = 2'd1;
  localparam logic [1:0] REG_DER_CNT  = 2'd2;

  typedef enum logic {
    KIND_LOAD,
    KIND_SAMPLE
  } gpid_kind_e;

  typedef struct packed {
    gpid_kind_e         kind;
    logic [1:0]         curve_select;
    logic [3:0]         node_index;
    logic signed [15:0] node_position;
    logic signed [31:0] node_value;
    logic signed [31:0] error_sample;
    logic signed [15:0] schedule_point;
  } gpid_item_t;

  typedef struct packed {
    logic [4:0] gain;
    logic [4:0] integral;
    logic [4:0] deriv;
  } gpid_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_IMUL,
    ST_IDIV,
    ST_SHIFT,
    ST_RDIV,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_MK,
    ST_OUT
  } gpid_state_e;

  // Drop the 16 fraction bits of a full product and saturate the magnitude.
  function automatic logic [60:0] qterm(input logic [MulPW-1:0] prod);
    logic [67:0] q;
    q = prod[83:16];
    if (q > SatBound) begin
      return SatBound[60:0];
    end
    return q[60:0];
  endfunction

endpackage

/* rtl/core/gpid_if.sv */
// Stream interfaces of the gain-scheduled incremental PID block.
// Independent of the package; used by the top level, front and back.
interface gpid_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [1:0]         curve_select;
  logic [3:0]         node_index;
  logic signed [15:0] node_position;
  logic signed [31:0] node_value;
  logic signed [31:0] error_sample;
  logic signed [15:0] schedule_point;

  modport source (output valid, mode, curve_select, node_index, node_position, node_value,
                  error_sample, schedule_point, input ready);
  modport sink (input valid, mode, curve_select, node_index, node_position, node_value,
                error_sample, schedule_point, output ready);
endinterface

interface gpid_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  logic               zero_integral;
  logic               saturated;

  modport source (output valid, drive, zero_integral, saturated, input ready);
  modport sink (input valid, drive, zero_integral, saturated, output ready);
endinterface

/* rtl/core/gpid_front.sv */
// Front end: accepts input transfers, drops bad loads and queues the rest.
// Depends on gpid_pkg and gpid_in_if.
module gpid_front #(
  parameter int Nodes = gpid_pkg::NodesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gpid_in_if.sink              in_i,
  output gpid_pkg::gpid_item_t head_o,
  output logic                 head_valid_o,
  input  logic                 head_ready_i
);
  import gpid_pkg::*;

  localparam int Depth = 2;

  gpid_item_t fifo_q [Depth];
  gpid_item_t item_w;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       accept, drop, push, pop;

  assign in_i.ready   = (cnt_q != 2'(Depth));
  assign accept       = in_i.valid && in_i.ready;
  // Classify: loads to a missing curve or slot are dropped here
  assign drop         = !in_i.mode &&
                        (in_i.curve_select == CURVE_NONE || int'(in_i.node_index) >= Nodes);
  assign push         = accept && !drop;
  assign head_valid_o = (cnt_q != 2'd0);
  assign pop          = head_valid_o && head_ready_i;
  assign head_o       = fifo_q[rd_ptr_q];

  always_comb begin
    item_w.kind           = in_i.mode ? KIND_SAMPLE : KIND_LOAD;
    item_w.curve_select   = in_i.curve_select;
    item_w.node_index     = in_i.node_index;
    item_w.node_position  = in_i.node_position;
    item_w.node_value     = in_i.node_value;
    item_w.error_sample   = in_i.error_sample;
    item_w.schedule_point = in_i.schedule_point;
  end

  // Queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= item_w;
  end

endmodule

/* rtl/core/gpid_mul.sv */
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on gpid_pkg for the operand widths.
module gpid_mul (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gpid_pkg::MulAW-1:0] a_i,
  input  logic [gpid_pkg::MulBW-1:0] b_i,
  output logic                       done_o,
  output logic [gpid_pkg::MulPW-1:0] prod_o
);
  import gpid_pkg::*;

  localparam int CW = $clog2(MulBW + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [MulPW-1:0] acc_q, a_sh_q;
  logic [MulBW-1:0] b_sh_q;

  assign done_o = done_q;
  assign prod_o = acc_q;

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MulBW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Accumulate one partial product per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q  <= '0;
      a_sh_q <= MulPW'(a_i);
      b_sh_q <= b_i;
    end else if (busy_q) begin
      if (b_sh_q[0]) acc_q <= acc_q + a_sh_q;
      a_sh_q <= a_sh_q << 1;
      b_sh_q <= b_sh_q >> 1;
    end
  end

endmodule

/* rtl/core/gpid_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gpid_pkg for the operand widths.
module gpid_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gpid_pkg::DivNW-1:0] num_i,
  input  logic [gpid_pkg::DivDW-1:0] den_i,
  output logic                       done_o,
  output logic [gpid_pkg::DivNW-1:0] quo_o
);
  import gpid_pkg::*;

  localparam int CW = $clog2(DivNW + 1);

  logic             busy_q, done_q;
  logic [CW-1:0]    cnt_q;
  logic [DivDW-1:0] rem_q, den_q;
  logic [DivNW-1:0] quo_q;
  logic [DivDW:0]   trial_w, diff_w;
  logic             fit_w;

  assign done_o  = done_q;
  assign quo_o   = quo_q;
  assign trial_w = {rem_q, quo_q[DivNW-1]};
  assign diff_w  = trial_w - {1'b0, den_q};
  assign fit_w   = (trial_w >= {1'b0, den_q});

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DivNW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift in one numerator bit, subtract where the divisor fits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= fit_w ? diff_w[DivDW-1:0] : trial_w[DivDW-1:0];
      quo_q <= {quo_q[DivNW-2:0], fit_w};
    end
  end

endmodule

/* rtl/core/gpid_back.sv */
// Back end: breakpoint memory, curve search, interpolation and control law sequencer.
// Depends on gpid_pkg, gpid_out_if, gpid_mul and gpid_div.
module gpid_back #(
  parameter int Nodes = gpid_pkg::NodesDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpid_pkg::gpid_cfg_t  cfg_i,
  input  gpid_pkg::gpid_item_t head_i,
  input  logic                 head_valid_i,
  output logic                 head_ready_o,
  gpid_out_if.source           out_o
);
  import gpid_pkg::*;

  localparam int Depth = Curves * Nodes;
  localparam int AW    = $clog2(Depth);
  localparam int IW    = $clog2(Nodes);
  localparam int NW    = $clog2(Nodes + 1);

  // Breakpoint memory {x, y}
  logic [47:0]   mem_q [Depth];
  logic [47:0]   rd_q;
  logic [AW-1:0] raddr, waddr, base_w;
  logic          we;

  gpid_state_e        state_q, state_d;
  logic [1:0]         curve_q, curve_d;
  logic [IW-1:0]      idx_q, idx_d;
  logic signed [15:0] p_q, p_d, px_q, px_d;
  logic signed [31:0] enew_q, enew_d, py_q, py_d;
  logic [15:0]        dx_q, dx_d;
  logic               ineg_q, ineg_d, mneg_q, mneg_d;
  logic signed [31:0] k_q, k_d, j_q, j_d, d_q, d_d;
  logic signed [31:0] e0_q, e0_d, e1_q, e1_d, e2_q, e2_d;
  logic signed [51:0] inner_q, inner_d;
  logic signed [31:0] res_drive_q, res_drive_d;
  logic               res_zi_q, res_zi_d, res_sat_q, res_sat_d;
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] out_drive_q, out_drive_d;
  logic               out_zi_q, out_zi_d, out_sat_q, out_sat_d;

  // Arithmetic units
  logic             mul_start, mul_done, div_start, div_done;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_prod;
  logic [DivNW-1:0] div_num, div_quo;
  logic [DivDW-1:0] div_den;

  // Datapath
  logic [4:0]         cnt_sel;
  logic [NW-1:0]      n_cur;
  logic signed [15:0] rx;
  logic signed [31:0] ry;
  logic signed [16:0] dx_w, pd_w;
  logic signed [32:0] dy_w;
  logic [32:0]        dy_mag, q33;
  logic signed [33:0] iq_w, ival_w, recip_w;
  logic signed [35:0] c0_w;
  logic signed [34:0] c1_w;
  logic [35:0]        c0_mag;
  logic [34:0]        c1_mag;
  logic [31:0]        d_mag, j_mag, k_mag, e0_mag, e1_mag, e2_mag;
  logic [60:0]        r61;
  logic signed [51:0] term_w, inner_sum;
  logic [51:0]        inner_mag;
  logic               fin;
  logic signed [31:0] fin_val;
  logic               sat_pos, sat_neg, out_fire;

  gpid_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  gpid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Node count in use for the current curve, clamped to 1..Nodes
  always_comb begin
    case (curve_q)
      CURVE_GAIN:     cnt_sel = cfg_i.gain;
      CURVE_INTEGRAL: cnt_sel = cfg_i.integral;
      default:        cnt_sel = cfg_i.deriv;
    endcase
    if (cnt_sel == 5'd0) begin
      n_cur = NW'(1);
    end else if (int'(cnt_sel) > Nodes) begin
      n_cur = NW'(Nodes);
    end else begin
      n_cur = NW'(cnt_sel);
    end
  end

  assign base_w = AW'(int'(curve_q) * Nodes);
  assign waddr  = AW'(int'(head_i.curve_select) * Nodes) + AW'(head_i.node_index);
  assign rx     = rd_q[47:32];
  assign ry     = rd_q[31:0];
  assign dx_w   = {rx[15], rx} - {px_q[15], px_q};
  assign pd_w   = {p_q[15], p_q} - {px_q[15], px_q};
  assign dy_w   = {ry[31], ry} - {py_q[31], py_q};
  assign dy_mag = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);

  // Interpolated value and reciprocal from the divider
  assign q33     = div_quo[32:0];
  assign iq_w    = ineg_q ? -$signed({1'b0, q33}) : $signed({1'b0, q33});
  assign ival_w  = {{2{py_q[31]}}, py_q} + iq_w;
  assign recip_w = j_q[31] ? -$signed({1'b0, q33}) : $signed({1'b0, q33});

  // Control law coefficients
  assign c0_w   = 36'sh10000 + {{2{recip_w[33]}}, recip_w} + {{4{d_q[31]}}, d_q};
  assign c1_w   = 35'sh10000 + {{2{d_q[31]}}, d_q, 1'b0};
  assign c0_mag = c0_w[35] ? 36'(-c0_w) : 36'(c0_w);
  assign c1_mag = c1_w[34] ? 35'(-c1_w) : 35'(c1_w);
  assign d_mag  = d_q[31] ? 32'(-d_q) : 32'(d_q);
  assign j_mag  = j_q[31] ? 32'(-j_q) : 32'(j_q);
  assign k_mag  = k_q[31] ? 32'(-k_q) : 32'(k_q);
  assign e0_mag = e0_q[31] ? 32'(-e0_q) : 32'(e0_q);
  assign e1_mag = e1_q[31] ? 32'(-e1_q) : 32'(e1_q);
  assign e2_mag = e2_q[31] ? 32'(-e2_q) : 32'(e2_q);

  // Signed Q16.16 term from the multiplier
  assign r61       = qterm(mul_prod);
  assign term_w    = mneg_q ? -$signed(r61[51:0]) : $signed(r61[51:0]);
  assign inner_sum = inner_q + term_w;
  assign inner_mag = inner_sum[51] ? 52'(-inner_sum) : 52'(inner_sum);
  assign sat_pos   = (r61 > 61'h7FFF_FFFF);
  assign sat_neg   = (r61 > 61'h8000_0000);

  assign out_fire      = out_valid_q && out_o.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.drive   = out_drive_q;
  assign out_o.zero_integral = out_zi_q;
  assign out_o.saturated     = out_sat_q;

  // Sequencer: next state and datapath control
  always_comb begin
    state_d     = state_q;
    curve_d     = curve_q;
    idx_d       = idx_q;
    p_d         = p_q;
    enew_d      = enew_q;
    px_d        = px_q;
    py_d        = py_q;
    dx_d        = dx_q;
    ineg_d      = ineg_q;
    mneg_d      = mneg_q;
    k_d         = k_q;
    j_d         = j_q;
    d_d         = d_q;
    e0_d        = e0_q;
    e1_d        = e1_q;
    e2_d        = e2_q;
    inner_d     = inner_q;
    res_drive_d = res_drive_q;
    res_zi_d    = res_zi_q;
    res_sat_d   = res_sat_q;
    out_valid_d = out_valid_q && !out_fire;
    out_drive_d = out_drive_q;
    out_zi_d    = out_zi_q;
    out_sat_d   = out_sat_q;
    head_ready_o = 1'b0;
    we          = 1'b0;
    raddr       = base_w;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_num     = '0;
    div_den     = '0;
    fin         = 1'b0;
    fin_val     = ry;

    case (state_q)
      ST_IDLE: begin
        head_ready_o = 1'b1;
        if (head_valid_i) begin
          if (head_i.kind == KIND_LOAD) begin
            we = 1'b1;
          end else begin
            p_d     = head_i.schedule_point;
            enew_d  = head_i.error_sample;
            curve_d = CURVE_GAIN;
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        raddr   = base_w;
        state_d = ST_FIRST;
      end
      ST_FIRST: begin
        px_d = rx;
        py_d = ry;
        if (p_q <= rx) begin
          fin = 1'b1;
        end else begin
          raddr   = base_w + AW'(n_cur - NW'(1));
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        if (p_q >= rx) begin
          fin = 1'b1;
        end else begin
          idx_d   = IW'(1);
          raddr   = base_w + AW'(1);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (p_q == rx) begin
          fin = 1'b1;
        end else if (p_q < rx) begin
          if (dx_w <= 17'sd0) begin
            fin     = 1'b1;
            fin_val = py_q;
          end else begin
            mul_start = 1'b1;
            mul_a     = MulAW'(dy_mag);
            mul_b     = MulBW'(pd_w[15:0]);
            dx_d      = dx_w[15:0];
            ineg_d    = dy_w[32];
            state_d   = ST_IMUL;
          end
        end else begin
          // Advance to the next breakpoint
          px_d  = rx;
          py_d  = ry;
          idx_d = idx_q + IW'(1);
          raddr = base_w + AW'(idx_q) + AW'(1);
        end
      end
      ST_IMUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_num   = mul_prod[DivNW-1:0];
          div_den   = DivDW'(dx_q);
          state_d   = ST_IDIV;
        end
      end
      ST_IDIV: begin
        if (div_done) begin
          fin     = 1'b1;
          fin_val = ival_w[31:0];
        end
      end
      ST_SHIFT: begin
        e2_d = e1_q;
        e1_d = e0_q;
        e0_d = enew_q;
        if (j_q == 32'sd0) begin
          res_drive_d = '0;
          res_zi_d    = 1'b1;
          res_sat_d   = 1'b0;
          state_d     = ST_OUT;
        end else begin
          div_start = 1'b1;
          div_num   = DivNW'(1) << 32;
          div_den   = j_mag;
          state_d   = ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (div_done) begin
          mul_start = 1'b1;
          mul_a     = MulAW'(c0_mag);
          mul_b     = e0_mag;
          mneg_d    = c0_w[35] ^ e0_q[31];
          state_d   = ST_M0;
        end
      end
      ST_M0: begin
        if (mul_done) begin
          inner_d   = term_w;
          mul_start = 1'b1;
          mul_a     = MulAW'(c1_mag);
          mul_b     = e1_mag;
          mneg_d    = ~(c1_w[34] ^ e1_q[31]);
          state_d   = ST_M1;
        end
      end
      ST_M1: begin
        // Sign flipped at start, so the term is added
        if (mul_done) begin
          inner_d   = inner_sum;
          mul_start = 1'b1;
          mul_a     = MulAW'(d_mag);
          mul_b     = e2_mag;
          mneg_d    = d_q[31] ^ e2_q[31];
          state_d   = ST_M2;
        end
      end
      ST_M2: begin
        if (mul_done) begin
          inner_d   = inner_sum;
          mul_start = 1'b1;
          mul_a     = inner_mag;
          mul_b     = k_mag;
          mneg_d    = inner_sum[51] ^ k_q[31];
          state_d   = ST_MK;
        end
      end
      ST_MK: begin
        if (mul_done) begin
          res_zi_d = 1'b0;
          if (mneg_q) begin
            res_sat_d   = sat_neg;
            res_drive_d = sat_neg ? 32'sh8000_0000 : -$signed(r61[31:0]);
          end else begin
            res_sat_d   = sat_pos;
            res_drive_d = sat_pos ? 32'sh7FFF_FFFF : $signed(r61[31:0]);
          end
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        // Hold until the output slot is free
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_drive_d = res_drive_q;
          out_zi_d    = res_zi_q;
          out_sat_d   = res_sat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Store a finished curve value and move to the next curve
    if (fin) begin
      case (curve_q)
        CURVE_GAIN:     k_d = fin_val;
        CURVE_INTEGRAL: j_d = fin_val;
        default:        d_d = fin_val;
      endcase
      if (curve_q == CURVE_DERIV) begin
        state_d = ST_SHIFT;
      end else begin
        curve_d = curve_q + 2'd1;
        state_d = ST_START;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      e0_q        <= '0;
      e1_q        <= '0;
      e2_q        <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      e0_q        <= e0_d;
      e1_q        <= e1_d;
      e2_q        <= e2_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    curve_q     <= curve_d;
    idx_q       <= idx_d;
    p_q         <= p_d;
    enew_q      <= enew_d;
    px_q        <= px_d;
    py_q        <= py_d;
    dx_q        <= dx_d;
    ineg_q      <= ineg_d;
    mneg_q      <= mneg_d;
    k_q         <= k_d;
    j_q         <= j_d;
    d_q         <= d_d;
    inner_q     <= inner_d;
    res_drive_q <= res_drive_d;
    res_zi_q    <= res_zi_d;
    res_sat_q   <= res_sat_d;
    out_drive_q <= out_drive_d;
    out_zi_q    <= out_zi_d;
    out_sat_q   <= out_sat_d;
  end

  // Breakpoint memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= {head_i.node_position, head_i.node_value};
    rd_q <= mem_q[raddr];
  end

endmodule

/* rtl/core/gain_scheduled_incremental_pid_top.sv */
// Gain-scheduled incremental PID block: APB register file, front queue and back sequencer.
// Depends on gpid_pkg, gpid_if, gpid_front and gpid_back.
//
// Usage:
//   in_i carries load and sample transfers (valid/ready). A load (mode 0) writes one
//   breakpoint {node_position, node_value} into curve curve_select; loads to curve 3 or
//   to a slot at index Nodes or above are dropped. A sample (mode 1) shifts error_sample
//   into the history, looks up K, J and D at schedule_point and returns one transfer on
//   out_o with drive, zero_integral and saturated. Loads return nothing.
//   The APB port holds the three node counts at byte addresses 0, 4 and 8.
// Sequencing:
//   A two-entry queue sits between front and back; the back works on one item at a time.
//   A load is written to the breakpoint memory straight from idle. A sample's time grows with n,
//   the nodes in use per curve, and is set by the one-bit-per-cycle divider (50 steps) and the
//   shift-add multiplier (32 steps).
// Reset clears the node counts to 1 and the error history to zero; breakpoints stay
// undefined until written. A stalled receiver holds the result in the output register;
// the back waits on the next result and the queue fills, then in_i.ready drops.
module gain_scheduled_incremental_pid_top #(
  parameter int Nodes = gpid_pkg::NodesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpid_in_if.sink     in_i,
  gpid_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gpid_pkg::*;

  gpid_cfg_t  cfg_q;
  gpid_item_t head;
  logic       head_valid, head_ready;

  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain: 5'd1, integral: 5'd1, deriv: 5'd1};
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_GAIN_CNT: cfg_q.gain     <= pwdata[4:0];
        REG_INT_CNT:  cfg_q.integral <= pwdata[4:0];
        REG_DER_CNT:  cfg_q.deriv    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_GAIN_CNT: prdata = {27'd0, cfg_q.gain};
      REG_INT_CNT:  prdata = {27'd0, cfg_q.integral};
      REG_DER_CNT:  prdata = {27'd0, cfg_q.deriv};
      default:      prdata = '0;
    endcase
  end

  gpid_front #(.Nodes(Nodes)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .head_o      (head),
    .head_valid_o(head_valid),
    .head_ready_i(head_ready)
  );

  gpid_back #(.Nodes(Nodes)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head),
    .head_valid_i(head_valid),
    .head_ready_o(head_ready),
    .out_o       (out_o)
  );

endmodule

/* rtl/core/gpid_checker.sv */
// Port-level checks on the result channel of the gain-scheduled incremental PID block.
// Bound to gain_scheduled_incremental_pid_top; no other dependencies.
module gpid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] drive_i,
  input logic        zero_integral_i,
  input logic        saturated_i
);

  // Hold a stalled result
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(drive_i) && $stable(zero_integral_i) && $stable(saturated_i))
    else $error("result changed while stalled");

  // Zero integral factor forces a zero, unclamped drive
  a_zero_integral: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && zero_integral_i |-> drive_i == 32'd0 && !saturated_i)
    else $error("zero integral result not zero");

  // Clamped drive sits at a range end
  a_sat_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> drive_i == 32'h7FFF_FFFF || drive_i == 32'h8000_0000)
    else $error("saturated drive not at a range end");

endmodule

bind gain_scheduled_incremental_pid_top gpid_checker u_gpid_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .drive_i        (out_o.drive),
  .zero_integral_i(out_o.zero_integral),
  .saturated_i    (out_o.saturated)
);

/* dv/gpid_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for the gain-scheduled incremental PID block: watches both streams and the APB port.
// Depends on gpid_pkg and gpid_if; predicts every sample result and compares it in order.
module gpid_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  gpid_in_if          in_m,
  gpid_out_if         out_m,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o
);
  import gpid_pkg::*;

  typedef struct {
    logic signed [31:0] drive;
    logic               zero_integral;
    logic               saturated;
  } pid_result_t;

  localparam longint QLimit = 64'sd1 <<< 60;

  logic signed [15:0] node_x [Curves][NodesDef];
  logic signed [31:0] node_y [Curves][NodesDef];
  logic signed [31:0] err_hist [3];
  logic [4:0]         node_cnt [Curves];
  pid_result_t        drive_queue [$];

  assign pending_o = drive_queue.size();

  // Q16.16 product with the magnitude truncated and bounded.
  function automatic longint fixed_mul(longint a, longint b);
    logic [127:0] ua;
    logic [127:0] ub;
    logic [127:0] prod;
    longint       r;
    ua   = (a < 0) ? -a : a;
    ub   = (b < 0) ? -b : b;
    prod = (ua * ub) >> 16;
    r    = (prod > QLimit) ? QLimit : longint'(prod);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  // Clamped piecewise-linear lookup of one curve.
  function automatic longint curve_at(int c, logic [4:0] cnt, longint p);
    int     n;
    longint dx;
    longint dy;
    n = (cnt == 0) ? 1 : ((cnt > NodesDef) ? NodesDef : cnt);
    if (p <= node_x[c][0]) return node_y[c][0];
    if (p >= node_x[c][n-1]) return node_y[c][n-1];
    for (int i = 1; i < n; i++) begin
      if (p == node_x[c][i]) return node_y[c][i];
      if (p < node_x[c][i]) begin
        dx = longint'(node_x[c][i]) - node_x[c][i-1];
        dy = longint'(node_y[c][i]) - node_y[c][i-1];
        if (dx <= 0) return node_y[c][i-1];
        return longint'(node_y[c][i-1]) + dy * (p - node_x[c][i-1]) / dx;
      end
    end
    return node_y[c][n-1];
  endfunction

  function automatic pid_result_t pid_drive(longint p);
    pid_result_t res;
    longint      k, j, d, c0, c1, inner, v;
    k = curve_at(CURVE_GAIN, node_cnt[CURVE_GAIN], p);
    j = curve_at(CURVE_INTEGRAL, node_cnt[CURVE_INTEGRAL], p);
    d = curve_at(CURVE_DERIV, node_cnt[CURVE_DERIV], p);
    res.drive         = '0;
    res.zero_integral = (j == 0);
    res.saturated     = 1'b0;
    if (j != 0) begin
      c0    = (64'sd1 <<< 16) + (64'sd1 <<< 32) / j + d;
      c1    = (64'sd1 <<< 16) + 2 * d;
      inner = fixed_mul(c0, err_hist[0]) - fixed_mul(c1, err_hist[1])
              + fixed_mul(d, err_hist[2]);
      v = fixed_mul(k, inner);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        res.saturated = 1'b1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        res.saturated = 1'b1;
      end
      res.drive = v[31:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pid_result_t exp_res;
    if (!rst_ni) begin
      fail_count_o = 0;
      drive_queue.delete();
      foreach (err_hist[i]) err_hist[i] = '0;
      foreach (node_cnt[i]) node_cnt[i] = 5'd1;
      foreach (node_x[c, i]) begin
        node_x[c][i] = '0;
        node_y[c][i] = '0;
      end
    end else begin
      // Track register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_GAIN_CNT: node_cnt[CURVE_GAIN]     = pwdata[4:0];
          REG_INT_CNT:  node_cnt[CURVE_INTEGRAL] = pwdata[4:0];
          REG_DER_CNT:  node_cnt[CURVE_DERIV]    = pwdata[4:0];
          default: ;
        endcase
      end
      // Predict on each input transfer
      if (in_m.valid && in_m.ready) begin
        if (in_m.mode == KIND_LOAD) begin
          if (in_m.curve_select != CURVE_NONE) begin
            node_x[in_m.curve_select][in_m.node_index] = in_m.node_position;
            node_y[in_m.curve_select][in_m.node_index] = in_m.node_value;
          end
        end else begin
          err_hist[2] = err_hist[1];
          err_hist[1] = err_hist[0];
          err_hist[0] = in_m.error_sample;
          drive_queue.push_back(pid_drive(in_m.schedule_point));
        end
      end
      // Compare each output transfer with the oldest prediction
      if (out_m.valid && out_m.ready) begin
        if (drive_queue.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result drive=%h", $time, out_m.drive);
        end else begin
          exp_res = drive_queue.pop_front();
          if (out_m.drive !== exp_res.drive) begin
            fail_count_o++;
            $display("%0t: drive expected %h actual %h", $time, exp_res.drive, out_m.drive);
          end
          if (out_m.zero_integral !== exp_res.zero_integral) begin
            fail_count_o++;
            $display("%0t: zero_integral expected %b actual %b", $time,
                     exp_res.zero_integral, out_m.zero_integral);
          end
          if (out_m.saturated !== exp_res.saturated) begin
            fail_count_o++;
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_res.saturated, out_m.saturated);
          end
        end
      end
    end
  end
endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps
// Top of the PID block testbench: clock, reset, APB and stream stimulus, verdict.
// Depends on gpid_pkg, gpid_if, the block's top level and gpid_scoreboard.
module tb;
  import gpid_pkg::*;

  localparam longint CycleLimit = 3_000_000;
  localparam int     DrainWait  = 600;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  longint      cycle_cnt;
  bit          no_idle;
  int          out_stall;
  int          sent;
  logic signed [15:0] loaded_x [Curves][NodesDef];

  gpid_in_if  in_if ();
  gpid_out_if out_if ();

  gain_scheduled_incremental_pid_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  gpid_scoreboard u_scoreboard (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_m        (in_if),
    .out_m       (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Stall the result side at random after each transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) out_stall = no_idle ? 0 : $urandom_range(0, 15);
      if (out_stall > 0) begin
        out_if.ready <= 1'b0;
        out_stall--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Present one transfer and hold it until accepted; valid stays high for a back-to-back item
  task automatic send(gpid_kind_e kind, logic [1:0] crv, logic [3:0] idx,
                      logic [15:0] pos, logic [31:0] val, logic [31:0] err, logic [15:0] pt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.mode           <= kind;
    in_if.curve_select   <= crv;
    in_if.node_index     <= idx;
    in_if.node_position  <= pos;
    in_if.node_value     <= val;
    in_if.error_sample   <= err;
    in_if.schedule_point <= pt;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    if (crv != CURVE_NONE && kind == KIND_LOAD) loaded_x[crv][idx] = pos;
  endtask

  // Drain every result, then let any trailing load finish
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value(int style);
    case (style)
      0: return 32'($signed($urandom_range(0, 262144)) - 131072);
      1: return $urandom;
      default: return '0;
    endcase
  endfunction

  // Reload a whole curve; ascending x unless shuffled
  task automatic load_curve(logic [1:0] crv, int style, bit ordered);
    int step;
    int base;
    step = $urandom_range(1, 4000);
    base = -32768 + $urandom_range(0, 65535 - 15 * step);
    for (int i = 0; i < NodesDef; i++)
      send(KIND_LOAD, crv, 4'(i), ordered ? 16'(base + i * step) : 16'($urandom),
           pick_value(style), $urandom, $urandom);
  endtask

  task automatic sample(logic [31:0] err, logic [15:0] pt);
    send(KIND_SAMPLE, 2'($urandom), 4'($urandom), 16'($urandom), $urandom, err, pt);
  endtask

  function automatic logic [15:0] pick_point();
    case ($urandom_range(0, 3))
      0: return loaded_x[$urandom_range(0, 2)][$urandom_range(0, 15)];
      1: return loaded_x[$urandom_range(0, 2)][$urandom_range(0, 15)] + 16'($urandom_range(1, 9));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    return ($urandom_range(0, 1) != 0) ? $urandom : pick_value(0);
  endfunction

  initial begin
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.mode   = KIND_LOAD;
    in_if.curve_select   = CURVE_GAIN;
    in_if.node_index     = '0;
    in_if.node_position  = '0;
    in_if.node_value     = '0;
    in_if.error_sample   = '0;
    in_if.schedule_point = '0;
    cycle_cnt    = 0;
    sent         = 0;
    no_idle      = 1'b0;
    rst_ni       = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill every breakpoint before the first lookup
    load_curve(CURVE_GAIN, 0, 1'b1);
    load_curve(CURVE_INTEGRAL, 0, 1'b1);
    load_curve(CURVE_DERIV, 0, 1'b1);

    // Directed: single-node curves at reset counts, range ends, exact nodes
    sample(32'h7fff_ffff, 16'h8000);
    sample(32'h8000_0000, 16'h7fff);
    sample(32'h0000_0000, loaded_x[CURVE_GAIN][0]);
    settle();
    reg_write(REG_GAIN_CNT, 32'd16);
    reg_write(REG_INT_CNT, 32'd0);
    reg_write(REG_DER_CNT, 32'd31);
    sample(32'h0001_0000, loaded_x[CURVE_GAIN][5]);
    sample(32'hffff_0000, loaded_x[CURVE_GAIN][5] + 16'd1);
    sample(32'h8000_0000, 16'h8000);
    sample(32'h7fff_ffff, 16'h7fff);
    // Ignored load to the unused curve code
    send(KIND_LOAD, CURVE_NONE, 4'hf, 16'hffff, 32'hffff_ffff, 32'h0, 16'h0);
    sample(32'h1234_5678, loaded_x[CURVE_DERIV][7]);
    settle();
    reg_write(REG_INT_CNT, 32'd16);
    // Zero integral factor, then a huge gain to force clamping
    load_curve(CURVE_INTEGRAL, 2, 1'b1);
    sample(32'h7fff_ffff, 16'h0000);
    sample(32'h8000_0000, 16'h7fff);
    load_curve(CURVE_GAIN, 1, 1'b1);
    load_curve(CURVE_INTEGRAL, 1, 1'b0);
    sample(32'h7fff_ffff, pick_point());
    sample(32'h8000_0000, pick_point());
    sample(32'h7fff_ffff, pick_point());
    settle();

    // Random phases over several node-count settings
    for (int ph = 0; sent < 800; ph++) begin
      reg_write(REG_GAIN_CNT, (ph % 4 == 0) ? 32'd1 : 32'($urandom_range(0, 31)));
      reg_write(REG_INT_CNT, (ph % 4 == 1) ? 32'd16 : 32'($urandom_range(0, 31)));
      reg_write(REG_DER_CNT, (ph % 4 == 2) ? 32'd0 : 32'($urandom));
      no_idle = (ph % 5 == 3);
      if ($urandom_range(0, 2) == 0) begin
        load_curve(2'($urandom_range(0, 2)), $urandom_range(0, 2), $urandom_range(0, 3) != 0);
      end
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 9) == 0)
          send(KIND_LOAD, 2'($urandom), 4'($urandom), 16'($urandom), pick_value($urandom_range(0, 2)),
               $urandom, $urandom);
        else
          sample(pick_error(), pick_point());
      end
      settle();
    end
    no_idle = 1'b0;
    settle();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
